[rtl/dpc_pkg.sv]
// dpc_pkg: shared types, port codes and drive geometry for the disk port controller
// no dependencies; imported by every module of the block

package dpc_pkg;

  localparam int DRIVE_COUNT = 16;
  localparam int DRIVE_W     = 4;
  localparam int SPT_W       = 15;
  localparam int LIN_W       = 23;
  localparam int DMA_W       = 16;
  localparam int MASK_W      = 16;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_DONE  = 2'd2
  } dpc_func_t;

  localparam logic [7:0] PORT_DRIVE  = 8'd10;
  localparam logic [7:0] PORT_TRACK  = 8'd11;
  localparam logic [7:0] PORT_SECTOR = 8'd12;
  localparam logic [7:0] PORT_CMD    = 8'd13;
  localparam logic [7:0] PORT_STATUS = 8'd14;
  localparam logic [7:0] PORT_DMAL   = 8'd15;
  localparam logic [7:0] PORT_DMAH   = 8'd16;

  localparam logic [7:0] STATUS_OK  = 8'h00;
  localparam logic [7:0] STATUS_ERR = 8'hFF;
  localparam logic [7:0] UNMAPPED   = 8'hFF;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] port;
    logic [7:0] wdata;
    logic       transfer_ok;
  } dpc_item_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic               cmd_valid;
    logic               cmd_is_write;
    logic [DRIVE_W-1:0] cmd_drive;
    logic [LIN_W-1:0]   linear_sector;
    logic [DMA_W-1:0]   dma_address;
  } dpc_result_t;

  // sectors per track of each drive slot
  function automatic logic [SPT_W-1:0] spt_of(input logic [DRIVE_W-1:0] drive);
    logic [SPT_W-1:0] spt;
    unique case (drive)
      4'd0, 4'd1, 4'd2, 4'd3:   spt = 15'd26;
      4'd8, 4'd9, 4'd10, 4'd11: spt = 15'd128;
      4'd15:                    spt = 15'd16484;
      default:                  spt = '0;
    endcase
    return spt;
  endfunction

endpackage

[rtl/dpc_in_if.sv]
// dpc_in_if: valid/ready channel carrying one CPU port access or storage completion
// depends on no package; the field widths are written out in the interface itself

interface dpc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] port;
  logic [7:0] wdata;
  logic       transfer_ok;

  modport source (output valid, output func, output port, output wdata,
                  output transfer_ok, input ready);
  modport sink   (input valid, input func, input port, input wdata,
                  input transfer_ok, output ready);
endinterface

[rtl/dpc_out_if.sv]
// dpc_out_if: valid/ready channel carrying one read byte or sector transfer command
// depends on dpc_pkg for field widths

interface dpc_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  read_data;
  logic                        cmd_valid;
  logic                        cmd_is_write;
  logic [dpc_pkg::DRIVE_W-1:0] cmd_drive;
  logic [dpc_pkg::LIN_W-1:0]   linear_sector;
  logic [dpc_pkg::DMA_W-1:0]   dma_address;

  modport source (output valid, output read_data, output cmd_valid, output cmd_is_write,
                  output cmd_drive, output linear_sector, output dma_address,
                  input ready);
  modport sink   (input valid, input read_data, input cmd_valid, input cmd_is_write,
                  input cmd_drive, input linear_sector, input dma_address,
                  output ready);
endinterface

[rtl/dpc_core.sv]
// dpc_core: controller registers, port decode and linear sector computation
// depends on dpc_pkg; fed by the input register, feeds dpc_out_reg

module dpc_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dpc_pkg::MASK_W-1:0]  cfg_wdata,
  input  logic                        fire,
  input  dpc_pkg::dpc_item_t          item,
  output dpc_pkg::dpc_result_t        res
);
  import dpc_pkg::*;

  logic [7:0]        drive_r, drive_nxt;
  logic [7:0]        track_r, track_nxt;
  logic [7:0]        sector_r, sector_nxt;
  logic [7:0]        command_r, command_nxt;
  logic [7:0]        dma_low_r, dma_low_nxt;
  logic [7:0]        dma_high_r, dma_high_nxt;
  logic [7:0]        status_r, status_nxt;
  logic [MASK_W-1:0] mask_r;

  logic               drive_ok;
  logic [SPT_W-1:0]   spt;
  logic [LIN_W-1:0]   pos;

  assign drive_ok = (drive_r < 8'(DRIVE_COUNT)) && mask_r[drive_r[DRIVE_W-1:0]];
  assign spt      = spt_of(drive_r[DRIVE_W-1:0]);
  assign pos      = LIN_W'(track_r) * LIN_W'(spt) + LIN_W'(sector_r);

  always_comb begin
    drive_nxt    = drive_r;
    track_nxt    = track_r;
    sector_nxt   = sector_r;
    command_nxt  = command_r;
    dma_low_nxt  = dma_low_r;
    dma_high_nxt = dma_high_r;
    status_nxt   = status_r;
    res          = '0;
    unique case (item.func)
      FUNC_WRITE: begin
        unique case (item.port)
          PORT_DRIVE:  drive_nxt    = item.wdata;
          PORT_TRACK:  track_nxt    = item.wdata;
          PORT_SECTOR: sector_nxt   = item.wdata;
          PORT_DMAL:   dma_low_nxt  = item.wdata;
          PORT_DMAH:   dma_high_nxt = item.wdata;
          PORT_CMD: begin
            command_nxt = item.wdata;
            // bad drive or a sector before the start of the disk
            if (!drive_ok || pos == '0) begin
              status_nxt = STATUS_ERR;
            end else begin
              res.cmd_valid     = 1'b1;
              res.cmd_is_write  = (item.wdata != 8'd0);
              res.cmd_drive     = drive_r[DRIVE_W-1:0];
              res.linear_sector = pos - LIN_W'(1);
              res.dma_address   = {dma_high_r, dma_low_r};
            end
          end
          default: ;
        endcase
      end
      FUNC_READ: begin
        res.read_data = (item.port == PORT_STATUS) ? status_r : UNMAPPED;
      end
      FUNC_DONE: begin
        status_nxt = item.transfer_ok ? STATUS_OK : STATUS_ERR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r    <= '0;
      track_r    <= '0;
      sector_r   <= '0;
      command_r  <= '0;
      dma_low_r  <= '0;
      dma_high_r <= '0;
      status_r   <= '0;
    end else if (fire) begin
      drive_r    <= drive_nxt;
      track_r    <= track_nxt;
      sector_r   <= sector_nxt;
      command_r  <= command_nxt;
      dma_low_r  <= dma_low_nxt;
      dma_high_r <= dma_high_nxt;
      status_r   <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

`ifndef SYNTHESIS
  a_cmd_reject_sets_err: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.func == FUNC_WRITE && item.port == PORT_CMD && !res.cmd_valid
    |=> status_r == STATUS_ERR)
    else $error("rejected command did not set error status");

  a_done_sets_status: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.func == FUNC_DONE
    |=> status_r == ($past(item.transfer_ok) ? STATUS_OK : STATUS_ERR))
    else $error("completion did not update status");

  a_cmd_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
    res.cmd_valid |-> drive_ok && pos != '0)
    else $error("command issued for an invalid drive or sector");

  a_cmd_byte_stored: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.func == FUNC_WRITE && item.port == PORT_CMD
    |=> command_r == $past(item.wdata))
    else $error("command byte not stored");
`endif

endmodule

[rtl/dpc_out_reg.sv]
// dpc_out_reg: result register that drives the out channel and holds it under stall
// depends on dpc_pkg and dpc_out_if

module dpc_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  dpc_pkg::dpc_result_t res,
  output logic                 can_load,
  dpc_out_if.source            out_ch
);
  import dpc_pkg::*;

  logic        valid_r;
  dpc_result_t data_r;

  assign can_load = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      data_r <= res;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.read_data     = data_r.read_data;
  assign out_ch.cmd_valid     = data_r.cmd_valid;
  assign out_ch.cmd_is_write  = data_r.cmd_is_write;
  assign out_ch.cmd_drive     = data_r.cmd_drive;
  assign out_ch.linear_sector = data_r.linear_sector;
  assign out_ch.dma_address   = data_r.dma_address;

endmodule

[rtl/disk_port_controller.sv]
// disk_port_controller: top level of the port-mapped disk controller
// depends on dpc_pkg, dpc_in_if, dpc_out_if, dpc_core and dpc_out_reg
//
// in_ch carries one transaction per CPU port write, port read or storage
// completion; out_ch returns exactly one transaction for each, holding the
// read byte or a sector transfer command (cmd_valid with drive, linear
// sector and dma address, other command fields zero when no command).
// cfg_we/cfg_wdata load the drive present mask; write it only while idle.
// An accepted transaction passes through the input register, then decode,
// register update and the track by sectors-per-track multiply in one pass
// into the result register. Throughput is one transaction per cycle while
// out_ch does not stall; the multiply sets the critical path, not the rate.
// Synchronous reset clears all controller registers, the present mask and
// both pipeline stages. When out_ch stalls, the result register holds, the
// input register fills, and in_ch.ready drops after that one extra
// transaction; nothing is lost or reordered.

module disk_port_controller (
  input  logic                       clk,
  input  logic                       rst_n,
  dpc_in_if.sink                     in_ch,
  dpc_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [dpc_pkg::MASK_W-1:0] cfg_wdata
);
  import dpc_pkg::*;

  logic        s1_valid_r;
  dpc_item_t   s1_item_r;
  logic        can_load;
  logic        fire;
  logic        in_fire;
  dpc_result_t res;

  assign fire        = s1_valid_r && can_load;
  assign in_ch.ready = !s1_valid_r || can_load;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= '{func: in_ch.func, port: in_ch.port, wdata: in_ch.wdata,
                     transfer_ok: in_ch.transfer_ok};
    end
  end

  dpc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (s1_item_r),
    .res       (res)
  );

  dpc_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted transaction missing from input register");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_ch.valid && !out_ch.ready |=> s1_valid_r && $stable(s1_item_r))
    else $error("input register moved while output stalled");

  a_fire_gives_output: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_ch.valid)
    else $error("processed transaction did not reach the output");
`endif

endmodule

[tb/dpc_checker.sv]
// dpc_checker: scoreboard for the disk port controller, keeps its own copy of the controller
// registers, predicts one result per accepted transaction and compares field by field
// depends on dpc_pkg for port codes, status bytes and the result layout

module dpc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic [7:0]                  in_port,
  input  logic [7:0]                  in_wdata,
  input  logic                        in_transfer_ok,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [7:0]                  out_read_data,
  input  logic                        out_cmd_valid,
  input  logic                        out_cmd_is_write,
  input  logic [dpc_pkg::DRIVE_W-1:0] out_cmd_drive,
  input  logic [dpc_pkg::LIN_W-1:0]   out_linear_sector,
  input  logic [dpc_pkg::DMA_W-1:0]   out_dma_address,
  input  logic                        cfg_we,
  input  logic [dpc_pkg::MASK_W-1:0]  cfg_wdata,
  output int                          outstanding,
  output int                          errors
);
  import dpc_pkg::*;

  logic [7:0]        drive_q;
  logic [7:0]        track_q;
  logic [7:0]        sector_q;
  logic [7:0]        command_q;
  logic [7:0]        dma_lo_q;
  logic [7:0]        dma_hi_q;
  logic [7:0]        status_q;
  logic [MASK_W-1:0] present_q;

  dpc_result_t expected_results[$];

  initial begin
    errors = 0;
    outstanding = 0;
  end

  function automatic logic [SPT_W-1:0] sectors_per_track(input logic [DRIVE_W-1:0] drive);
    if (drive < 4)
      return 15'd26;
    else if (drive[3:2] == 2'b10)
      return 15'd128;
    else if (drive == 4'd15)
      return 15'd16484;
    return '0;
  endfunction

  // updates the shadow registers and returns what the block must answer
  function automatic dpc_result_t predict_access(input logic [1:0] func, input logic [7:0] port,
                                                 input logic [7:0] wdata, input logic ok);
    dpc_result_t res;
    logic [31:0] pos;
    res = '0;
    case (func)
      FUNC_WRITE: begin
        case (port)
          PORT_DRIVE:  drive_q = wdata;
          PORT_TRACK:  track_q = wdata;
          PORT_SECTOR: sector_q = wdata;
          PORT_DMAL:   dma_lo_q = wdata;
          PORT_DMAH:   dma_hi_q = wdata;
          PORT_CMD: begin
            command_q = wdata;
            if (drive_q >= 8'(DRIVE_COUNT) || !present_q[drive_q[3:0]]) begin
              status_q = STATUS_ERR;
            end else begin
              pos = 32'(track_q) * 32'(sectors_per_track(drive_q[3:0])) + 32'(sector_q);
              // track 0 sector 0 would point before the first sector
              if (pos == 0) begin
                status_q = STATUS_ERR;
              end else begin
                res.cmd_valid     = 1'b1;
                res.cmd_is_write  = (command_q != 8'd0);
                res.cmd_drive     = drive_q[3:0];
                res.linear_sector = LIN_W'(pos - 32'd1);
                res.dma_address   = {dma_hi_q, dma_lo_q};
              end
            end
          end
          default: ;
        endcase
      end
      FUNC_READ:
        res.read_data = (port == PORT_STATUS) ? status_q : UNMAPPED;
      FUNC_DONE:
        status_q = ok ? STATUS_OK : STATUS_ERR;
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    dpc_result_t want;
    if (!rst_n) begin
      drive_q   = '0;
      track_q   = '0;
      sector_q  = '0;
      command_q = '0;
      dma_lo_q  = '0;
      dma_hi_q  = '0;
      status_q  = '0;
      present_q = '0;
      expected_results.delete();
    end else begin
      // a result never belongs to the transaction accepted at the same edge
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", 32'(want.read_data), 32'(out_read_data));
          check_field("cmd_valid", 32'(want.cmd_valid), 32'(out_cmd_valid));
          check_field("cmd_is_write", 32'(want.cmd_is_write), 32'(out_cmd_is_write));
          check_field("cmd_drive", 32'(want.cmd_drive), 32'(out_cmd_drive));
          check_field("linear_sector", 32'(want.linear_sector), 32'(out_linear_sector));
          check_field("dma_address", 32'(want.dma_address), 32'(out_dma_address));
        end
      end
      if (cfg_we)
        present_q = cfg_wdata;
      if (in_valid && in_ready)
        expected_results.push_back(predict_access(in_func, in_port, in_wdata, in_transfer_ok));
    end
    outstanding <= expected_results.size();
  end

endmodule

[tb/disk_port_controller_tb.sv]
// disk_port_controller_tb: drives port accesses and completions into the disk port controller
// with random idling and a long output hold-off, and reports the verdict
// depends on dpc_pkg, dpc_in_if, dpc_out_if, disk_port_controller and dpc_checker

module disk_port_controller_tb;
  import dpc_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int LONG_HOLD_CYCLES = 60;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [MASK_W-1:0]   cfg_wdata;
  int                  outstanding;
  int                  errors;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  holds_wanted;
  int                  holds_done;
  int                  items_sent;

  dpc_in_if  in_ch();
  dpc_out_if out_ch();

  disk_port_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  dpc_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_func           (in_ch.func),
    .in_port           (in_ch.port),
    .in_wdata          (in_ch.wdata),
    .in_transfer_ok    (in_ch.transfer_ok),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_read_data     (out_ch.read_data),
    .out_cmd_valid     (out_ch.cmd_valid),
    .out_cmd_is_write  (out_ch.cmd_is_write),
    .out_cmd_drive     (out_ch.cmd_drive),
    .out_linear_sector (out_ch.linear_sector),
    .out_dma_address   (out_ch.dma_address),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .outstanding       (outstanding),
    .errors            (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("disk_port_controller_tb: errors");
    $finish;
  end

  // result side: random stalls, plus a long hold-off whenever one is requested
  initial begin
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_wanted) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // valid stays high after a transaction so back-to-back items need no toggle
  task automatic send_item(input logic [1:0] func, input logic [7:0] port,
                           input logic [7:0] wdata, input logic ok);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= func;
    in_ch.port        <= port;
    in_ch.wdata       <= wdata;
    in_ch.transfer_ok <= ok;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic port_write(input logic [7:0] port, input logic [7:0] wdata);
    send_item(FUNC_WRITE, port, wdata, 1'($urandom_range(1)));
  endtask

  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_present_mask(input logic [MASK_W-1:0] mask);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // register setup and command, sometimes followed by completion and status poll
  task automatic run_transfer();
    logic [7:0] drive;
    logic [7:0] track;
    logic [7:0] sector;
    drive  = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
    track  = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255));
    sector = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
    if ($urandom_range(3) != 0) port_write(PORT_DRIVE, drive);
    if ($urandom_range(3) != 0) port_write(PORT_TRACK, track);
    if ($urandom_range(3) != 0) port_write(PORT_SECTOR, sector);
    if ($urandom_range(1) != 0) port_write(PORT_DMAL, 8'($urandom));
    if ($urandom_range(1) != 0) port_write(PORT_DMAH, 8'($urandom));
    port_write(PORT_CMD, ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom));
    if ($urandom_range(1) != 0)
      send_item(FUNC_DONE, 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
    if ($urandom_range(1) != 0)
      send_item(FUNC_READ, PORT_STATUS, 8'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic send_noise();
    logic [7:0] port;
    port = ($urandom_range(1) == 0) ? 8'($urandom_range(20)) : 8'($urandom);
    send_item(2'($urandom_range(3)), port, 8'($urandom), 1'($urandom_range(1)));
  endtask

  initial begin
    int seg_end;
    logic [MASK_W-1:0] mask;
    holds_wanted  = 0;
    items_sent    = 0;
    send_idle_pct = 17;
    recv_idle_pct = 63;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.func        <= FUNC_WRITE;
    in_ch.port        <= '0;
    in_ch.wdata       <= '0;
    in_ch.transfer_ok <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no drive present after reset
    port_write(PORT_CMD, 8'd0);
    load_present_mask(16'hFFFF);
    send_item(FUNC_READ, PORT_STATUS, 8'd0, 1'b0);
    send_item(FUNC_READ, 8'd0, 8'd0, 1'b0);
    send_item(FUNC_READ, 8'hFF, 8'hFF, 1'b1);
    // sector before start of disk
    port_write(PORT_SECTOR, 8'd0);
    port_write(PORT_CMD, 8'd0);
    send_item(FUNC_DONE, 8'd0, 8'd0, 1'b1);
    send_item(FUNC_READ, PORT_STATUS, 8'd0, 1'b0);
    port_write(PORT_SECTOR, 8'd1);
    port_write(PORT_CMD, 8'd0);
    // largest geometry, track and sector
    port_write(PORT_DRIVE, 8'd15);
    port_write(PORT_TRACK, 8'hFF);
    port_write(PORT_SECTOR, 8'hFF);
    port_write(PORT_DMAL, 8'hFF);
    port_write(PORT_DMAH, 8'hFF);
    port_write(PORT_CMD, 8'hFF);
    // drive number out of range
    port_write(PORT_DRIVE, 8'hFF);
    port_write(PORT_CMD, 8'd1);
    // drive with no sectors per track
    port_write(PORT_DRIVE, 8'd4);
    port_write(PORT_SECTOR, 8'd0);
    port_write(PORT_CMD, 8'd2);
    // status port write is ignored
    port_write(PORT_STATUS, 8'h55);
    send_item(FUNC_DONE, 8'd0, 8'd0, 1'b0);
    send_item(FUNC_UNUSED, PORT_STATUS, 8'hAA, 1'b1);
    send_item(FUNC_READ, PORT_STATUS, 8'd0, 1'b0);

    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0:       mask = 16'h0000;
        1:       mask = 16'h8F0F;
        2, 4:    mask = 16'($urandom);
        default: mask = 16'hFFFF;
      endcase
      load_present_mask(mask);
      if (seg < 2) begin
        send_idle_pct = 17;
        recv_idle_pct = 63;
      end else if (seg < 4) begin
        send_idle_pct = 63;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      seg_end = items_sent + 230;
      while (items_sent < seg_end) begin
        if (seg >= 4 && items_sent >= seg_end - 180 && holds_wanted < seg - 3)
          holds_wanted++;
        if ($urandom_range(4) == 0)
          send_noise();
        else
          run_transfer();
      end
    end

    drain_pipeline();
    if (errors == 0)
      $display("disk_port_controller_tb: clean");
    else
      $display("disk_port_controller_tb: errors");
    $finish;
  end

endmodule
